// File: hdl/etfp_pkg.sv
`timescale 1ns / 1ps
// Package for the escape-time fractal point core: word types, sequencer states,
// register indexes and fixed-point helpers. No dependencies.
package etfp_pkg;

  localparam int unsigned DefMaxColumns    = 4096;
  localparam int unsigned DefMaxRows       = 4096;
  localparam int unsigned DefEscapeRadSq   = 4;
  localparam int unsigned DefFractionBits  = 56;
  localparam int unsigned DerivFracBits    = 40;
  localparam int unsigned CfgIndexWidth    = 4;

  typedef enum logic [CfgIndexWidth-1:0] {
    REG_MODE       = 4'd0,
    REG_X_START    = 4'd1,
    REG_Y_START    = 4'd2,
    REG_X_STEP     = 4'd3,
    REG_Y_STEP     = 4'd4,
    REG_JULIA_REAL = 4'd5,
    REG_JULIA_IMAG = 4'd6,
    REG_MAX_ITER   = 4'd7
  } reg_index_e;

  typedef enum logic [1:0] {
    MODE_MANDEL  = 2'd0,
    MODE_DIST    = 2'd1,
    MODE_FIXED_C = 2'd2,
    MODE_SPARE   = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PX, ST_PY, ST_SQR, ST_SQI, ST_TEST, ST_ZRI,
    ST_D0, ST_D1, ST_D2, ST_D3, ST_UPD, ST_OUT
  } seq_state_e;

  typedef struct packed {
    logic [11:0] column;
    logic [11:0] row;
  } item_t;

  typedef struct packed {
    logic [15:0]        iteration_count;
    logic signed [63:0] final_real;
    logic signed [63:0] final_imag;
    logic signed [63:0] deriv_real;
    logic signed [63:0] deriv_imag;
    logic               deriv_saturated;
  } result_t;

  // Clamp a 128-bit two's complement value to 64 bits; bit 64 flags a clamp.
  function automatic logic [64:0] sat64(input logic [127:0] v);
    logic [64:0] r;
    if (v[127:63] == {65{v[63]}}) begin
      r = {1'b0, v[63:0]};
    end else if (v[127]) begin
      r = {1'b1, 1'b1, 63'd0};
    end else begin
      r = {1'b1, 1'b0, {63{1'b1}}};
    end
    return r;
  endfunction

  function automatic logic [127:0] sext(input logic [63:0] v);
    return {{64{v[63]}}, v};
  endfunction

endpackage

// File: hdl/etfp_mul.sv
`timescale 1ns / 1ps
// Shared signed 64 x 64 -> 128 multiplier, one 32 x 32 partial product a cycle.
// Depends on nothing; used by escape_time_fractal_point_core.
module etfp_mul (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [63:0]  a_i,
  input  logic [63:0]  b_i,
  output logic         done_o,
  output logic [127:0] prod_o
);

  logic [63:0]  ma_q, mb_q;
  logic         neg_q;
  logic [1:0]   step_q;
  logic         run_q, fin_q, done_q;
  logic [127:0] acc_q, prod_q;
  logic [31:0]  op_a, op_b;
  logic [63:0]  pp;
  logic [127:0] pp_shift;

  assign op_a = step_q[0] ? ma_q[63:32] : ma_q[31:0];
  assign op_b = step_q[1] ? mb_q[63:32] : mb_q[31:0];
  assign pp   = {32'd0, op_a} * {32'd0, op_b};

  always_comb begin
    case ({1'b0, step_q[0]} + {1'b0, step_q[1]})
      2'd0:    pp_shift = {64'd0, pp};
      2'd1:    pp_shift = {32'd0, pp, 32'd0};
      default: pp_shift = {pp, 64'd0};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= 2'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q  <= 1'b1;
        step_q <= 2'd0;
      end else if (run_q) begin
        step_q <= step_q + 2'd1;
        if (step_q == 2'd3) begin
          run_q <= 1'b0;
          fin_q <= 1'b1;
        end
      end else if (fin_q) begin
        fin_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ma_q  <= a_i[63] ? (~a_i + 64'd1) : a_i;
      mb_q  <= b_i[63] ? (~b_i + 64'd1) : b_i;
      neg_q <= a_i[63] ^ b_i[63];
      acc_q <= '0;
    end else if (run_q) begin
      acc_q <= acc_q + pp_shift;
    end else if (fin_q) begin
      prod_q <= neg_q ? (~acc_q + 128'd1) : acc_q;
    end
  end

  assign done_o = done_q;
  assign prod_o = prod_q;

endmodule

// File: hdl/escape_time_fractal_point_core.sv
`timescale 1ns / 1ps
// Escape-time fractal point core: sequencer, registers and datapath around one
// shared multiplier. Depends on etfp_pkg and etfp_mul.
//
//  channel  | handshake                     | word
//  ---------+-------------------------------+---------------------------------
//  item     | start_i, busy_o (take: !busy) | item_i   (column, row)
//  result   | result_valid_o, one cycle     | result_o (count, z, derivative)
//  config   | cfg_valid_i, cfg_ready_o      | cfg_index_i, cfg_data_i
//
// Each 64x64 product holds its state in the shared multiplier through issue,
// four partial products, sign fix and done. Setup takes 2 products; an iteration
// takes 3 products plus test and update, or 7 products in distance mode.
// Reset clears the sequencer and sets registers at once; the receiver cannot stall.
module escape_time_fractal_point_core #(
  parameter int unsigned MAX_COLUMNS      = etfp_pkg::DefMaxColumns,
  parameter int unsigned MAX_ROWS         = etfp_pkg::DefMaxRows,
  parameter int unsigned ESCAPE_RADIUS_SQ = etfp_pkg::DefEscapeRadSq,
  parameter int unsigned FRACTION_BITS    = etfp_pkg::DefFractionBits
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  etfp_pkg::item_t                     item_i,
  output logic                                result_valid_o,
  output etfp_pkg::result_t                   result_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [etfp_pkg::CfgIndexWidth-1:0]  cfg_index_i,
  input  logic [63:0]                         cfg_data_i
);

  import etfp_pkg::*;

  localparam logic [63:0] Limit = 64'(ESCAPE_RADIUS_SQ) << FRACTION_BITS;

  // configuration registers
  logic [1:0]  mode_q;
  logic [63:0] x_start_q, y_start_q, x_step_q, y_step_q, jr_q, ji_q;
  logic [15:0] max_iter_q;

  // working state
  seq_state_e  state_q, state_d;
  logic        mul_wait_q, mul_start, mul_done;
  logic [63:0] mul_a, mul_b;
  logic [127:0] prod;
  logic [11:0] column_q, row_q;
  logic        oor_q, dist_q, dsat_q;
  logic [63:0] zr_q, zi_q, cr_q, ci_q, dr_q, di_q, zr2_q, zi2_q, nzi_q;
  logic [127:0] t_q, u_q;
  logic [15:0] count_q;

  logic        take, distance, julia, oor;
  logic [64:0] px_s, py_s, sqr_s, nzi_s, nzr_s, dr_s, di_s;
  logic        escaped, is_zero, more;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = (state_q != ST_IDLE);
  assign take        = start_i && !busy_o;
  assign distance    = (mode_q == MODE_DIST);
  assign julia       = (mode_q == MODE_FIXED_C);
  assign oor = ({5'd0, item_i.column} >= 17'(MAX_COLUMNS)) ||
               ({5'd0, item_i.row} >= 17'(MAX_ROWS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_MANDEL;
      x_start_q  <= '0;
      y_start_q  <= '0;
      x_step_q   <= '0;
      y_step_q   <= '0;
      jr_q       <= '0;
      ji_q       <= '0;
      max_iter_q <= 16'd256;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_MODE:       mode_q     <= cfg_data_i[1:0];
        REG_X_START:    x_start_q  <= cfg_data_i;
        REG_Y_START:    y_start_q  <= cfg_data_i;
        REG_X_STEP:     x_step_q   <= cfg_data_i;
        REG_Y_STEP:     y_step_q   <= cfg_data_i;
        REG_JULIA_REAL: jr_q       <= cfg_data_i;
        REG_JULIA_IMAG: ji_q       <= cfg_data_i;
        REG_MAX_ITER:   max_iter_q <= cfg_data_i[15:0];
        default:        ;
      endcase
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    case (state_q)
      ST_PX:   begin mul_a = {52'd0, column_q}; mul_b = x_step_q; end
      ST_PY:   begin mul_a = {52'd0, row_q};    mul_b = y_step_q; end
      ST_SQR:  begin mul_a = zr_q; mul_b = zr_q; end
      ST_SQI:  begin mul_a = zi_q; mul_b = zi_q; end
      ST_ZRI:  begin mul_a = zr_q; mul_b = zi_q; end
      ST_D0:   begin mul_a = zr_q; mul_b = dr_q; end
      ST_D1:   begin mul_a = zi_q; mul_b = di_q; end
      ST_D2:   begin mul_a = zr_q; mul_b = di_q; end
      ST_D3:   begin mul_a = zi_q; mul_b = dr_q; end
      default: begin mul_a = zr_q; mul_b = zi_q; end
    endcase
  end

  always_comb begin
    case (state_q)
      ST_PX, ST_PY, ST_SQR, ST_SQI, ST_ZRI, ST_D0, ST_D1, ST_D2, ST_D3:
        mul_start = !mul_wait_q;
      default: mul_start = 1'b0;
    endcase
  end

  etfp_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  // datapath results
  assign px_s  = sat64(sext(x_start_q) + prod);
  assign py_s  = sat64(sext(y_start_q) + prod);
  assign sqr_s = sat64(128'($signed(prod) >>> FRACTION_BITS));
  assign nzi_s = sat64(128'($signed(prod) >>> (FRACTION_BITS - 1)) + sext(ci_q));
  assign nzr_s = sat64(sext(zr2_q) - sext(zi2_q) + sext(cr_q));
  assign dr_s  = sat64(128'($signed(t_q) >>> (FRACTION_BITS - 1)) +
                       (128'd1 << DerivFracBits));
  assign di_s  = sat64(128'($signed(u_q) >>> (FRACTION_BITS - 1)));
  assign escaped = ({1'b0, zr2_q} + {1'b0, zi2_q}) >= {1'b0, Limit};
  assign is_zero = (nzr_s[63:0] == 64'd0) && (nzi_q == 64'd0);
  assign more    = ({1'b0, count_q} + 17'd1) < {1'b0, max_iter_q};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (take) state_d = oor ? ST_OUT : ST_PX;
      ST_PX:   if (mul_done) state_d = ST_PY;
      ST_PY:   if (mul_done) state_d = (max_iter_q == 16'd0) ? ST_OUT : ST_SQR;
      ST_SQR:  if (mul_done) state_d = ST_SQI;
      ST_SQI:  if (mul_done) state_d = ST_TEST;
      ST_TEST: state_d = escaped ? ST_OUT : ST_ZRI;
      ST_ZRI:  if (mul_done) state_d = dist_q ? ST_D0 : ST_UPD;
      ST_D0:   if (mul_done) state_d = ST_D1;
      ST_D1:   if (mul_done) state_d = ST_D2;
      ST_D2:   if (mul_done) state_d = ST_D3;
      ST_D3:   if (mul_done) state_d = ST_UPD;
      ST_UPD:  state_d = (is_zero || !more) ? ST_OUT : ST_SQR;
      ST_OUT:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      mul_wait_q <= 1'b0;
    end else begin
      state_q <= state_d;
      // hold the wait flag from issue until the product is back
      if (mul_done)       mul_wait_q <= 1'b0;
      else if (mul_start) mul_wait_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: if (take) begin
        column_q <= item_i.column;
        row_q    <= item_i.row;
        oor_q    <= oor;
        dist_q   <= distance;
        dsat_q   <= 1'b0;
        count_q  <= 16'd0;
        dr_q     <= 64'd1 << DerivFracBits;
        di_q     <= '0;
      end
      ST_PX: if (mul_done) begin
        zr_q <= px_s[63:0];
        cr_q <= julia ? jr_q : px_s[63:0];
      end
      ST_PY: if (mul_done) begin
        zi_q <= py_s[63:0];
        ci_q <= julia ? ji_q : py_s[63:0];
      end
      ST_SQR:  if (mul_done) zr2_q <= sqr_s[63:0];
      ST_SQI:  if (mul_done) zi2_q <= sqr_s[63:0];
      ST_ZRI:  if (mul_done) nzi_q <= nzi_s[63:0];
      ST_D0:   if (mul_done) t_q <= prod;
      ST_D1:   if (mul_done) t_q <= t_q - prod;
      ST_D2:   if (mul_done) u_q <= prod;
      ST_D3:   if (mul_done) u_q <= u_q + prod;
      ST_UPD: begin
        zr_q <= nzr_s[63:0];
        zi_q <= nzi_q;
        // advance the derivative from the old z, flag any clamp
        if (dist_q) begin
          dr_q   <= dr_s[63:0];
          di_q   <= di_s[63:0];
          dsat_q <= dsat_q | dr_s[64] | di_s[64];
        end
        count_q <= is_zero ? max_iter_q : count_q + 16'd1;
      end
      default: ;
    endcase
  end

  // drop everything to zero for a pixel outside the image
  assign result_valid_o = (state_q == ST_OUT);
  always_comb begin
    result_o = '0;
    if (!oor_q) begin
      result_o.iteration_count = count_q;
      result_o.final_real      = zr_q;
      result_o.final_imag      = zi_q;
      if (dist_q) begin
        result_o.deriv_real      = dr_q;
        result_o.deriv_imag      = di_q;
        result_o.deriv_saturated = dsat_q;
      end
    end
  end

endmodule

// File: hdl/etfp_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the escape-time fractal point core, bound to the top.
// Depends on no package; its ports are plain signals of the top level.
module etfp_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic result_valid_o
);

  a_result_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy_o) else $error("result word shown while idle");

  a_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("taken word did not set busy");

  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !busy_o) else $error("busy held after result word");

  a_result_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o) else $error("result word repeated");

endmodule

bind escape_time_fractal_point_core etfp_checker u_etfp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .result_valid_o (result_valid_o)
);

// File: sim/tb_escape_time_fractal_point_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for escape_time_fractal_point_core: directed and random
// pixel words checked against a fixed-point escape-time predictor.
// Depends on etfp_pkg and the core RTL only.

module tb_escape_time_fractal_point_core;
  import etfp_pkg::*;

  localparam int unsigned FracBits   = DefFractionBits;
  localparam longint      CycleLimit = 20_000_000;
  localparam logic [CfgIndexWidth-1:0] CfgUnusedIndex = 4'd9;

  // Hold the expected result words in order and compare each result word
  // against the oldest one.
  class point_scoreboard;
    result_t expected_q[$];
    int      errors;

    function new();
      errors = 0;
    endfunction

    function void note(result_t exp_word);
      expected_q.push_back(exp_word);
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task check(result_t got);
      result_t exp_word;
      if (expected_q.size() == 0) begin
        report("result word with nothing expected");
        return;
      end
      exp_word = expected_q.pop_front();
      if (got.iteration_count !== exp_word.iteration_count)
        report($sformatf("iteration_count %0d, expected %0d",
                         got.iteration_count, exp_word.iteration_count));
      if (got.final_real !== exp_word.final_real)
        report($sformatf("final_real %h, expected %h", got.final_real, exp_word.final_real));
      if (got.final_imag !== exp_word.final_imag)
        report($sformatf("final_imag %h, expected %h", got.final_imag, exp_word.final_imag));
      if (got.deriv_real !== exp_word.deriv_real)
        report($sformatf("deriv_real %h, expected %h", got.deriv_real, exp_word.deriv_real));
      if (got.deriv_imag !== exp_word.deriv_imag)
        report($sformatf("deriv_imag %h, expected %h", got.deriv_imag, exp_word.deriv_imag));
      if (got.deriv_saturated !== exp_word.deriv_saturated)
        report($sformatf("deriv_saturated %b, expected %b",
                         got.deriv_saturated, exp_word.deriv_saturated));
    endtask
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start_i = 1'b0;
  logic             busy_o;
  item_t            item_i = '0;
  logic             result_valid_o;
  result_t          result_o;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [CfgIndexWidth-1:0] cfg_index_i = '0;
  logic [63:0]      cfg_data_i = '0;

  point_scoreboard  sb = new();
  longint           cycles = 0;

  // Shadow copy of the register file, updated on every accepted config write.
  mode_e            sh_mode = MODE_MANDEL;
  logic [63:0]      sh_x_start = '0, sh_y_start = '0, sh_x_step = '0, sh_y_step = '0;
  logic [63:0]      sh_julia_re = '0, sh_julia_im = '0;
  logic [15:0]      sh_max_iter = 16'd256;

  escape_time_fractal_point_core dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Exact signed 64x64 product in 128 bits.
  function automatic logic signed [127:0] prod128(logic [63:0] a, logic [63:0] b);
    logic signed [127:0] wa, wb;
    wa = {{64{a[63]}}, a};
    wb = {{64{b[63]}}, b};
    return wa * wb;
  endfunction

  function automatic logic signed [127:0] widen(logic [63:0] v);
    return {{64{v[63]}}, v};
  endfunction

  // Clamp to the signed 64-bit range; raise flag on any clamp.
  function automatic logic [63:0] clamp_q(logic signed [127:0] v, inout bit flag);
    if (v > widen(64'h7FFF_FFFF_FFFF_FFFF)) begin
      flag = 1'b1;
      return 64'h7FFF_FFFF_FFFF_FFFF;
    end
    if (v < widen(64'h8000_0000_0000_0000)) begin
      flag = 1'b1;
      return 64'h8000_0000_0000_0000;
    end
    return v[63:0];
  endfunction

  // Iterate one pixel with the shadow registers.
  function automatic result_t escape_point(item_t px_word);
    result_t             res;
    bit                  zsat, dsat, dist_on, julia;
    logic [63:0]         px, py, cr, ci, zr, zi, dr, di, zr2, zi2, nzr, nzi;
    logic signed [127:0] t, u;
    logic [64:0]         mag;
    int unsigned         cnt, maxit;
    zsat = 1'b0;
    dsat = 1'b0;
    dist_on = (sh_mode == MODE_DIST);
    julia = (sh_mode == MODE_FIXED_C);
    res = '0;
    if (px_word.column >= DefMaxColumns || px_word.row >= DefMaxRows) return res;
    px = clamp_q(widen(sh_x_start) + prod128({52'd0, px_word.column}, sh_x_step), zsat);
    py = clamp_q(widen(sh_y_start) + prod128({52'd0, px_word.row}, sh_y_step), zsat);
    cr = julia ? sh_julia_re : px;
    ci = julia ? sh_julia_im : py;
    zr = px;
    zi = py;
    dr = 64'd1 << DerivFracBits;
    di = '0;
    maxit = sh_max_iter;
    for (cnt = 0; cnt < maxit; cnt++) begin
      zr2 = clamp_q(prod128(zr, zr) >>> FracBits, zsat);
      zi2 = clamp_q(prod128(zi, zi) >>> FracBits, zsat);
      mag = {1'b0, zr2} + {1'b0, zi2};
      if (mag >= (65'(DefEscapeRadSq) << FracBits)) break;
      if (dist_on) begin
        t = prod128(zr, dr) - prod128(zi, di);
        u = prod128(zr, di) + prod128(zi, dr);
        t = (t >>> (FracBits - 1)) + widen(64'd1 << DerivFracBits);
        u = u >>> (FracBits - 1);
        dr = clamp_q(t, dsat);
        di = clamp_q(u, dsat);
      end
      nzr = clamp_q(widen(zr2) - widen(zi2) + widen(cr), zsat);
      nzi = clamp_q((prod128(zr, zi) >>> (FracBits - 1)) + widen(ci), zsat);
      zr = nzr;
      zi = nzi;
      // Trapped at the origin: report the full limit.
      if (zr == '0 && zi == '0) begin
        cnt = maxit;
        break;
      end
    end
    res.iteration_count = cnt[15:0];
    res.final_real = zr;
    res.final_imag = zi;
    if (dist_on) begin
      res.deriv_real = dr;
      res.deriv_imag = di;
      res.deriv_saturated = dsat;
    end
    return res;
  endfunction

  // Monitor: note each accepted pixel word, check each result word.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) sb.note(escape_point(item_i));
      if (result_valid_o) sb.check(result_o);
    end
  end

  // Watchdog: drop the run if it hangs.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("escape_time_fractal_point_core verification failed");
      $finish;
    end
  end

  // Write one register; the shadow copy follows the accepted write.
  task cfg_write(logic [CfgIndexWidth-1:0] idx, logic [63:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_MODE:       sh_mode = mode_e'(data[1:0]);
      REG_X_START:    sh_x_start = data;
      REG_Y_START:    sh_y_start = data;
      REG_X_STEP:     sh_x_step = data;
      REG_Y_STEP:     sh_y_step = data;
      REG_JULIA_REAL: sh_julia_re = data;
      REG_JULIA_IMAG: sh_julia_im = data;
      REG_MAX_ITER:   sh_max_iter = data[15:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task set_view(logic [1:0] mode, logic [63:0] xs, logic [63:0] ys, logic [63:0] xd,
                logic [63:0] yd, logic [63:0] jr, logic [63:0] ji, logic [63:0] maxit);
    cfg_write(REG_MODE, {62'd0, mode});
    cfg_write(REG_X_START, xs);
    cfg_write(REG_Y_START, ys);
    cfg_write(REG_X_STEP, xd);
    cfg_write(REG_Y_STEP, yd);
    cfg_write(REG_JULIA_REAL, jr);
    cfg_write(REG_JULIA_IMAG, ji);
    cfg_write(REG_MAX_ITER, maxit);
  endtask

  // Hold until every expected word has come and the core has gone idle.
  task drain();
    @(negedge clk_i);
    start_i = 1'b0;
    while (sb.expected_q.size() != 0 || busy_o) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // Offer one pixel word and hold it until taken; start stays high on return.
  task send_pixel(logic [11:0] col, logic [11:0] row);
    @(negedge clk_i);
    start_i = 1'b1;
    item_i.column = col;
    item_i.row = row;
    do @(posedge clk_i); while (busy_o);
  endtask

  // Random gap before a word, taken with the given chance in percent.
  task maybe_idle(int pct);
    if ($urandom_range(99) < pct) begin
      @(negedge clk_i);
      start_i = 1'b0;
      repeat ($urandom_range(4)) @(negedge clk_i);
    end
  endtask

  localparam logic [63:0] QOne  = 64'd1 << FracBits;
  localparam logic [63:0] QMin  = 64'h8000_0000_0000_0000;
  localparam logic [63:0] QMax  = 64'h7FFF_FFFF_FFFF_FFFF;

  initial begin
    int          pct;
    logic [63:0] xs, ys, xd, yd, jr, ji;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset view: every point is the origin, trapped at once.
    send_pixel(12'd0, 12'd0);
    send_pixel(12'hFFF, 12'hFFF);
    drain();

    // Point just inside -2 on the real axis: the derivative saturates.
    set_view(MODE_DIST, -(2 * QOne) + 1, '0, 64'd1, 64'd1, '0, '0, 64'd40);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'hFFF, 12'd0);
    send_pixel(12'd0, 12'hFFF);
    drain();

    // Coordinate extremes saturate the point; it escapes at once.
    set_view(MODE_MANDEL, QMin, QMax, QMax, QMin, QMin, QMax, 64'hFFFF);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'hFFF, 12'hFFF);
    send_pixel(12'hFFF, 12'd0);
    send_pixel(12'd0, 12'hFFF);
    drain();

    // Julia with a zero limit, then a short one.
    set_view(MODE_FIXED_C, -(QOne + (QOne >> 1)), -(QOne + (QOne >> 1)), 64'd3 << 44,
             64'd3 << 44, -(QOne >> 1) - (QOne >> 2), QOne / 10, 64'd0);
    send_pixel(12'd100, 12'd2000);
    send_pixel(12'd2048, 12'd2048);
    drain();
    cfg_write(REG_MAX_ITER, 64'd20);
    send_pixel(12'd2048, 12'd2048);
    send_pixel(12'd1000, 12'd3000);
    drain();

    // Spare mode acts as plain Mandelbrot; the origin traps at the full limit.
    set_view(MODE_SPARE, '0, '0, '0, '0, '0, '0, {48'hFFFF_FFFF_FFFF, 16'hFFFF});
    cfg_write(CfgUnusedIndex, {64{1'b1}});
    send_pixel(12'd7, 12'd9);
    drain();

    // Random phases: mostly a view over the set, sometimes raw coordinates.
    for (int ph = 0; ph < 8; ph++) begin
      pct = (ph % 4 == 1) ? 47 : (ph % 4 == 3) ? 25 : 0;
      if (ph == 5) begin
        xs = {$urandom, $urandom}; ys = {$urandom, $urandom};
        xd = {$urandom, $urandom}; yd = {$urandom, $urandom};
      end else begin
        xs = -(2 * QOne) + (64'($urandom_range(1 << 20)) << 18);
        ys = -(QOne + (QOne >> 1));
        xd = 64'd3 << ($urandom_range(44, 40));
        yd = 64'd3 << ($urandom_range(44, 40));
      end
      jr = $urandom_range(1) ? {{8{1'b1}}, 56'($urandom)} : {8'd0, 56'($urandom) << 24};
      ji = {{8{$urandom_range(1) ? 1'b1 : 1'b0}}, 56'({$urandom, $urandom})};
      set_view(2'($urandom_range(3)), xs, ys, xd, yd, jr, ji,
               {48'($urandom), 16'($urandom_range(24))});
      for (int n = 0; n < 125; n++) begin
        maybe_idle(pct);
        send_pixel(12'($urandom), 12'($urandom));
        // Let the core drain once mid-phase.
        if (n == 60 && ph == 2) drain();
      end
      drain();
    end

    repeat (100) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("escape_time_fractal_point_core verification clean");
    end else begin
      $display("escape_time_fractal_point_core verification failed");
    end
    $finish;
  end

endmodule
